// ----- design/dhws_pkg.sv -----
// ----------------------------------------------------------------------------
// dhws_pkg
// Shared constants, state encodings and control groups of the dominant hue
// window search block.
// ----------------------------------------------------------------------------
package dhws_pkg;

	localparam int HUE_BINS_DEF   = 360;
	localparam int COUNT_BITS_DEF = 24;
	localparam int FINAL_SPAN     = 5;
	localparam int HUE_W          = 9;

	typedef enum logic [2:0] {
		C_CLEAR,
		C_ACCUM,
		C_FLUSH,
		C_SEARCH,
		C_RESULT
	} ctl_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_SLIDE,
		S_DRAIN,
		S_NEXT,
		S_FINAL,
		S_FDRAIN,
		S_DONE
	} srch_state_t;

	typedef enum logic [2:0] {
		TAG_NONE,
		TAG_INIT,
		TAG_INIT_LAST,
		TAG_IN,
		TAG_OUT,
		TAG_FINAL,
		TAG_FINAL_FIRST
	} rd_tag_t;

	typedef struct packed {
		logic take;
		logic clr_any;
	} acc_ctl_t;

	typedef struct packed {
		logic any_chromatic;
		logic last_taken;
	} acc_sts_t;

endpackage

// ----- design/dhws_pix_if.sv -----
// ----------------------------------------------------------------------------
// dhws_pix_if
// Pixel channel: one hue word per transfer with achromatic and last marks.
// ----------------------------------------------------------------------------
interface dhws_pix_if;
	logic                       valid;
	logic                       ready;
	logic [dhws_pkg::HUE_W-1:0] hue;
	logic                       achromatic;
	logic                       last;

	modport source (output valid, output hue, output achromatic, output last, input ready);
	modport sink (input valid, input hue, input achromatic, input last, output ready);
endinterface

// ----- design/dhws_res_if.sv -----
// ----------------------------------------------------------------------------
// dhws_res_if
// Result channel: one winning hue word per image.
// ----------------------------------------------------------------------------
interface dhws_res_if;
	logic                       valid;
	logic                       ready;
	logic [dhws_pkg::HUE_W-1:0] winning_hue;
	logic                       no_hue;

	modport source (output valid, output winning_hue, output no_hue, input ready);
	modport sink (input valid, input winning_hue, input no_hue, output ready);
endinterface

// ----- design/dhws_ram.sv -----
// ----------------------------------------------------------------------------
// dhws_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read of the address written in the same cycle returns the old word.
// ----------------------------------------------------------------------------
module dhws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/dhws_accum.sv -----
// ----------------------------------------------------------------------------
// dhws_accum
// Histogram update: read the bin of each accepted pixel, add one with
// saturation in the next cycle and write back for chromatic in-range hues only, forwarding the previous write.
// ----------------------------------------------------------------------------
module dhws_accum #(
	parameter int HUE_BINS   = dhws_pkg::HUE_BINS_DEF,
	parameter int COUNT_BITS = dhws_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dhws_pix_if.sink                    pix,
	input  dhws_pkg::acc_ctl_t          ctl,
	output dhws_pkg::acc_sts_t          sts,
	output logic [$clog2(HUE_BINS)-1:0] raddr,
	input  logic [COUNT_BITS-1:0]       rdata,
	output logic                        we,
	output logic [$clog2(HUE_BINS)-1:0] waddr,
	output logic [COUNT_BITS-1:0]       wdata
);
	import dhws_pkg::*;

	localparam int ADDR_W = $clog2(HUE_BINS);

	logic                  take;
	logic                  hit;
	logic                  vld_s1;
	logic [ADDR_W-1:0]     hue_s1;
	logic                  fwd_vld_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;
	logic                  any_q;
	logic [COUNT_BITS-1:0] old_cnt;
	logic [COUNT_BITS-1:0] new_cnt;

	assign pix.ready = ctl.take;
	assign take      = pix.valid && pix.ready;
	assign hit       = !pix.achromatic && (32'(pix.hue) < 32'(HUE_BINS));
	assign raddr     = ADDR_W'(pix.hue);

	assign old_cnt = (fwd_vld_q && fwd_addr_q == hue_s1) ? fwd_data_q : rdata;
	assign new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + COUNT_BITS'(1);

	assign we    = vld_s1;
	assign waddr = hue_s1;
	assign wdata = new_cnt;

	assign sts.any_chromatic = any_q;
	assign sts.last_taken    = take && pix.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
			any_q     <= 1'b0;
		end else begin
			vld_s1    <= take && hit;
			fwd_vld_q <= vld_s1;
			if (ctl.clr_any) begin
				any_q <= 1'b0;
			end else if (take && hit) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		hue_s1     <= raddr;
		fwd_addr_q <= hue_s1;
		fwd_data_q <= new_cnt;
	end

endmodule

// ----- design/dhws_search.sv -----
// ----------------------------------------------------------------------------
// dhws_search
// Window search sequencer: one histogram read per cycle, sliding window sums
// over shrinking ranges, then the largest bin of the final range.
// ----------------------------------------------------------------------------
module dhws_search #(
	parameter int HUE_BINS   = dhws_pkg::HUE_BINS_DEF,
	parameter int COUNT_BITS = dhws_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [COUNT_BITS-1:0]       rdata,
	output logic [$clog2(HUE_BINS)-1:0] raddr,
	output logic                        done,
	output logic [$clog2(HUE_BINS)-1:0] winner
);
	import dhws_pkg::*;

	localparam int ADDR_W = $clog2(HUE_BINS);
	localparam int IDX_W  = ADDR_W + 1;
	localparam int LEN_W  = $clog2(HUE_BINS + 1);
	localparam int SUM_W  = COUNT_BITS + ADDR_W;
	localparam logic [IDX_W-1:0] BINS_I = IDX_W'(HUE_BINS);
	localparam logic [LEN_W-1:0] BINS_L = LEN_W'(HUE_BINS);
	localparam logic [LEN_W-1:0] SPAN_L = LEN_W'(FINAL_SPAN);

	function automatic logic [ADDR_W-1:0] wrap_idx(input logic [IDX_W-1:0] v);
		logic [IDX_W-1:0] w;
		w = (v >= BINS_I) ? v - BINS_I : v;
		return w[ADDR_W-1:0];
	endfunction

	srch_state_t           state_q, state_d;
	logic [ADDR_W-1:0]     start_q;
	logic [ADDR_W-1:0]     best_start_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      k_q;
	logic [LEN_W-1:0]      j_q;
	logic                  circ_q;
	logic                  ph_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W-1:0]      acc_q;
	logic [SUM_W-1:0]      best_q;
	logic [COUNT_BITS-1:0] top_q;
	logic [ADDR_W-1:0]     winner_q;
	rd_tag_t               tag_s1;
	logic [ADDR_W-1:0]     idx_s1;
	logic [ADDR_W-1:0]     cand_s1;

	rd_tag_t               issue_tag;
	logic [LEN_W-1:0]      half;
	logic [LEN_W-1:0]      slide_end;
	logic [IDX_W-1:0]      base;
	logic [ADDR_W-1:0]     seq_idx;
	logic [ADDR_W-1:0]     in_idx;
	logic [ADDR_W-1:0]     out_idx;
	logic [ADDR_W-1:0]     cand_idx;
	logic [SUM_W-1:0]      rd_ext;
	logic [SUM_W-1:0]      nsum;
	logic                  init_end;

	assign half      = len_q >> 1;
	assign slide_end = circ_q ? len_q - LEN_W'(1) : len_q - half;
	assign base      = IDX_W'(start_q);
	assign seq_idx   = wrap_idx(base + IDX_W'(k_q));
	assign in_idx    = wrap_idx(base + IDX_W'(j_q) + IDX_W'(half) - IDX_W'(1));
	assign out_idx   = wrap_idx(base + IDX_W'(j_q) - IDX_W'(1));
	assign cand_idx  = wrap_idx(base + IDX_W'(j_q));
	assign init_end  = (k_q == half - LEN_W'(1));
	assign rd_ext    = SUM_W'(rdata);
	assign nsum      = acc_q - rd_ext;
	assign winner    = winner_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_INIT;
			end
			S_INIT: begin
				if (init_end) state_d = S_SLIDE;
			end
			S_SLIDE: begin
				if (ph_q && j_q == slide_end) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_NEXT;
			S_NEXT: begin
				state_d = (half > SPAN_L) ? S_INIT : S_FINAL;
			end
			S_FINAL: begin
				if (k_q == len_q - LEN_W'(1)) state_d = S_FDRAIN;
			end
			S_FDRAIN: state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		raddr     = seq_idx;
		issue_tag = TAG_NONE;
		done      = 1'b0;
		case (state_q)
			S_INIT: begin
				issue_tag = init_end ? TAG_INIT_LAST : TAG_INIT;
			end
			S_SLIDE: begin
				raddr     = ph_q ? out_idx : in_idx;
				issue_tag = ph_q ? TAG_OUT : TAG_IN;
			end
			S_FINAL: begin
				issue_tag = (k_q == '0) ? TAG_FINAL_FIRST : TAG_FINAL;
			end
			S_DONE:  done = 1'b1;
			default: issue_tag = TAG_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tag_s1  <= TAG_NONE;
			start_q <= '0;
			len_q   <= BINS_L;
			circ_q  <= 1'b1;
			k_q     <= '0;
			j_q     <= '0;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			tag_s1  <= issue_tag;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						start_q <= '0;
						len_q   <= BINS_L;
						circ_q  <= 1'b1;
						k_q     <= '0;
					end
				end
				S_INIT: begin
					if (init_end) begin
						k_q  <= '0;
						j_q  <= LEN_W'(1);
						ph_q <= 1'b0;
					end else begin
						k_q <= k_q + LEN_W'(1);
					end
				end
				S_SLIDE: begin
					ph_q <= !ph_q;
					if (ph_q) j_q <= j_q + LEN_W'(1);
				end
				S_NEXT: begin
					start_q <= best_start_q;
					len_q   <= half;
					circ_q  <= 1'b0;
					k_q     <= '0;
				end
				S_FINAL: k_q <= k_q + LEN_W'(1);
				default: k_q <= k_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= raddr;
		cand_s1 <= cand_idx;
		if (state_q == S_INIT && k_q == '0) sum_q <= '0;
		case (tag_s1)
			TAG_INIT: sum_q <= sum_q + rd_ext;
			TAG_INIT_LAST: begin
				sum_q        <= sum_q + rd_ext;
				best_q       <= sum_q + rd_ext;
				best_start_q <= start_q;
			end
			TAG_IN: acc_q <= sum_q + rd_ext;
			TAG_OUT: begin
				sum_q <= nsum;
				if (nsum > best_q) begin
					best_q       <= nsum;
					best_start_q <= cand_s1;
				end
			end
			TAG_FINAL_FIRST: begin
				top_q    <= rdata;
				winner_q <= idx_s1;
			end
			TAG_FINAL: begin
				if (rdata > top_q) begin
					top_q    <= rdata;
					winner_q <= idx_s1;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

endmodule

// ----- design/dominant_hue_window_search_top.sv -----
// ----------------------------------------------------------------------------
// dominant_hue_window_search_top
// Hue histogram in one RAM, window search over it on the last pixel of an
// image with any hue, one result word per image.
//
//   channel  dir  word fields                       accepted when
//   pix      in   hue[8:0], achromatic, last        pix.valid && pix.ready
//   res      out  winning_hue[8:0], no_hue          res.valid && res.ready
//
// Pixels are taken one per cycle while the block accumulates; the bin update
// is a read-modify-write with the previous write forwarded. The last pixel of
// an image with any hue starts the search, which reads one bin per cycle from
// the single RAM read port. After a result with any hue the RAM is cleared,
// also right after reset; no pixel is taken meanwhile. A full result register
// holds back the next result and with it the pixels that follow.
// ----------------------------------------------------------------------------
module dominant_hue_window_search_top #(
	parameter int HUE_BINS   = dhws_pkg::HUE_BINS_DEF,
	parameter int COUNT_BITS = dhws_pkg::COUNT_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	dhws_pix_if.sink    pix,
	dhws_res_if.source  res
);
	import dhws_pkg::*;

	localparam int ADDR_W = $clog2(HUE_BINS);

	ctl_state_t            state_q, state_d;
	logic [ADDR_W-1:0]     clr_cnt_q;
	logic                  out_vld_q;
	logic [HUE_W-1:0]      winning_hue_q;
	logic                  no_hue_q;

	acc_ctl_t              acc_ctl;
	acc_sts_t              acc_sts;
	logic [ADDR_W-1:0]     acc_raddr;
	logic                  acc_we;
	logic [ADDR_W-1:0]     acc_waddr;
	logic [COUNT_BITS-1:0] acc_wdata;
	logic [ADDR_W-1:0]     srch_raddr;
	logic                  srch_start;
	logic                  srch_done;
	logic [ADDR_W-1:0]     srch_winner;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;

	logic                  slot_free;
	logic                  load;
	logic                  clr_end;

	assign slot_free = !out_vld_q || res.ready;
	assign clr_end   = (clr_cnt_q == ADDR_W'(HUE_BINS - 1));

	dhws_accum #(
		.HUE_BINS   (HUE_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.ctl    (acc_ctl),
		.sts    (acc_sts),
		.raddr  (acc_raddr),
		.rdata  (ram_rdata),
		.we     (acc_we),
		.waddr  (acc_waddr),
		.wdata  (acc_wdata)
	);

	dhws_search #(
		.HUE_BINS   (HUE_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (srch_start),
		.rdata  (ram_rdata),
		.raddr  (srch_raddr),
		.done   (srch_done),
		.winner (srch_winner)
	);

	dhws_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (HUE_BINS)
	) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_CLEAR: begin
				if (clr_end) state_d = C_ACCUM;
			end
			C_ACCUM: begin
				if (acc_sts.last_taken) state_d = C_FLUSH;
			end
			C_FLUSH: begin
				state_d = acc_sts.any_chromatic ? C_SEARCH : C_RESULT;
			end
			C_SEARCH: begin
				if (srch_done) state_d = C_RESULT;
			end
			C_RESULT: begin
				if (slot_free) state_d = acc_sts.any_chromatic ? C_CLEAR : C_ACCUM;
			end
			default: state_d = C_CLEAR;
		endcase
	end

	always_comb begin
		acc_ctl.take    = (state_q == C_ACCUM);
		acc_ctl.clr_any = 1'b0;
		srch_start      = 1'b0;
		load            = 1'b0;
		ram_we          = acc_we;
		ram_waddr       = acc_waddr;
		ram_wdata       = acc_wdata;
		ram_raddr       = acc_raddr;
		case (state_q)
			C_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			C_FLUSH:  srch_start = acc_sts.any_chromatic;
			C_SEARCH: ram_raddr  = srch_raddr;
			C_RESULT: begin
				load            = slot_free;
				acc_ctl.clr_any = slot_free;
			end
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= C_CLEAR;
			clr_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				clr_cnt_q <= '0;
			end else if (state_q == C_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			winning_hue_q <= acc_sts.any_chromatic ? HUE_W'(srch_winner) : '0;
			no_hue_q      <= !acc_sts.any_chromatic;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.winning_hue = winning_hue_q;
	assign res.no_hue      = no_hue_q;

	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_SEARCH |-> !ram_we)
		else $error("histogram written during search");

	a_no_update_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_CLEAR |-> !acc_we)
		else $error("bin update lost to clearing pass");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_done |-> state_q == C_SEARCH)
		else $error("search finished outside search phase");

	a_no_hue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.no_hue |-> res.winning_hue == '0)
		else $error("nonzero hue with no_hue set");

endmodule

// ----- sim/tb_dominant_hue_window_search_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dominant_hue_window_search_top
// Drives images of pixel hues into the dominant hue search block and checks
// every result word against a local histogram and window search predictor.
// A short directed set covers the field extremes, grey-only images,
// out-of-range hues and wrap-around clusters. Random images follow,
// mostly clustered or peaked, with grey and out-of-range noise. Both sides
// idle in random bursts until the tail of the run.
// ----------------------------------------------------------------------------
module tb_dominant_hue_window_search_top;

	import dhws_pkg::*;

	localparam int HUE_BINS   = HUE_BINS_DEF;
	localparam int COUNT_BITS = COUNT_BITS_DEF;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
	localparam int RANDOM_ITEMS = 1250;
	localparam int DRAIN_CYCLES = 2000;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic             achromatic;
		logic             last;
		logic             hold;
	} pix_word_t;

	typedef struct packed {
		logic [HUE_W-1:0] winning_hue;
		logic             no_hue;
	} res_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dhws_pix_if pix_ch ();
	dhws_res_if res_ch ();

	dominant_hue_window_search_top #(
		.HUE_BINS(HUE_BINS),
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch),
		.res(res_ch)
	);

	pix_word_t   pending_pixels[$];
	res_word_t   expected_hues[$];
	int unsigned bin_count[HUE_BINS];
	bit          seen_hue;
	int          err_cnt;
	int          idle_left;
	int          stall_left;
	logic        quiet_tail;

	always #5 clk = ~clk;

	function automatic int unsigned wrap_hue(int unsigned i);
		return (i >= HUE_BINS) ? i - HUE_BINS : i;
	endfunction

	function automatic logic [HUE_W-1:0] dominant_bin();
		int unsigned lo, span, half, last_at, stop_at, in_at, next_lo, pick;
		longint unsigned acc, best, top;
		bit circ, found;
		lo = 0;
		span = HUE_BINS;
		circ = 1'b1;
		while (circ || span > FINAL_SPAN) begin
			half = span / 2;
			last_at = lo + span - 1;
			stop_at = circ ? last_at : last_at - half + 1;
			acc = 0;
			for (int unsigned i = lo; i < lo + half; i++)
				acc += bin_count[wrap_hue(i)];
			best = acc;
			next_lo = lo;
			for (int unsigned i = lo + 1; i <= stop_at; i++) begin
				in_at = i + half - 1;
				if (circ && in_at > last_at)
					in_at -= span;
				acc = acc + bin_count[wrap_hue(in_at)] - bin_count[wrap_hue(i - 1)];
				if (acc > best) begin
					best = acc;
					next_lo = wrap_hue(i);
				end
			end
			lo = next_lo;
			span = half;
			circ = 1'b0;
		end
		found = 1'b0;
		top = 0;
		pick = 0;
		for (int unsigned i = lo; i < lo + span; i++) begin
			if (!found || bin_count[wrap_hue(i)] > top) begin
				found = 1'b1;
				top = bin_count[wrap_hue(i)];
				pick = wrap_hue(i);
			end
		end
		return pick[HUE_W-1:0];
	endfunction

	task automatic count_pixel(pix_word_t w);
		res_word_t r;
		if (!w.achromatic && w.hue < HUE_BINS) begin
			if (bin_count[w.hue] < COUNT_MAX)
				bin_count[w.hue]++;
			seen_hue = 1'b1;
		end
		if (w.last) begin
			r.no_hue = !seen_hue;
			r.winning_hue = seen_hue ? dominant_bin() : '0;
			expected_hues.push_back(r);
			foreach (bin_count[i])
				bin_count[i] = 0;
			seen_hue = 1'b0;
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	task automatic add_pixel(int hue, bit achromatic, bit last, bit hold);
		pix_word_t w;
		w.hue = hue[HUE_W-1:0];
		w.achromatic = achromatic;
		w.last = last;
		w.hold = hold;
		pending_pixels.push_back(w);
	endtask

	task automatic add_image(int len, bit hold);
		int kind, center, spread, h, r;
		int peaks[3];
		bit grey;
		kind = $urandom_range(0, 19);
		center = $urandom_range(0, 359);
		spread = $urandom_range(0, 40);
		for (int p = 0; p < 3; p++)
			peaks[p] = $urandom_range(0, 359);
		for (int k = 0; k < len; k++) begin
			grey = 1'b0;
			if (kind < 2) begin
				grey = 1'b1;
				h = $urandom_range(0, 511);
			end else if (kind < 8) begin
				h = $urandom_range(0, 359);
			end else if (kind < 16) begin
				h = (center + 360 + $urandom_range(0, 2 * spread) - spread) % 360;
			end else begin
				h = peaks[$urandom_range(0, 2)];
			end
			r = $urandom_range(0, 31);
			if (r == 0) begin
				grey = 1'b1;
				h = $urandom_range(0, 511);
			end else if (r == 1 && !grey) begin
				h = $urandom_range(360, 511);
			end
			add_pixel(h, grey, k == len - 1, hold && k == 0);
		end
	endtask

	always @(posedge clk) begin
		bit show;
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
			quiet_tail <= 1'b0;
		end else begin
			quiet_tail <= pending_pixels.size() < 150;
			if (!pix_ch.valid || pix_ch.ready) begin
				if (pix_ch.valid)
					count_pixel(pending_pixels.pop_front());
				show = 1'b0;
				if (idle_left > 0)
					idle_left--;
				else if (!quiet_tail && $urandom_range(0, 7) == 0)
					idle_left = $urandom_range(0, 3);
				else if (pending_pixels.size() > 0 &&
						!(pending_pixels[0].hold && expected_hues.size() > 0))
					show = 1'b1;
				pix_ch.valid <= show;
				if (show) begin
					pix_ch.hue <= pending_pixels[0].hue;
					pix_ch.achromatic <= pending_pixels[0].achromatic;
					pix_ch.last <= pending_pixels[0].last;
				end
			end
		end
	end

	always @(posedge clk) begin
		res_word_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_hues.size() == 0) begin
					report_mismatch("result word with none pending", res_ch.winning_hue, -1);
				end else begin
					want = expected_hues.pop_front();
					if (res_ch.winning_hue !== want.winning_hue)
						report_mismatch("winning_hue", res_ch.winning_hue, want.winning_hue);
					if (res_ch.no_hue !== want.no_hue)
						report_mismatch("no_hue", res_ch.no_hue, want.no_hue);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int total, len;
		pix_ch.valid = 1'b0;
		pix_ch.hue = '0;
		pix_ch.achromatic = 1'b0;
		pix_ch.last = 1'b0;
		res_ch.ready = 1'b0;
		quiet_tail = 1'b0;
		err_cnt = 0;
		idle_left = 0;
		stall_left = 0;
		seen_hue = 1'b0;
		foreach (bin_count[i])
			bin_count[i] = 0;

		add_pixel(0, 0, 1, 0);
		add_pixel(359, 0, 1, 0);
		add_pixel(511, 1, 0, 0);
		add_pixel(0, 1, 1, 0);
		add_pixel(360, 0, 0, 1);
		add_pixel(511, 0, 1, 0);
		add_pixel(256, 0, 0, 0);
		add_pixel(511, 0, 0, 0);
		add_pixel(255, 0, 1, 0);
		add_pixel(358, 0, 0, 0);
		add_pixel(359, 0, 0, 0);
		add_pixel(0, 0, 0, 0);
		add_pixel(1, 0, 0, 0);
		add_pixel(1, 0, 1, 0);
		add_pixel(100, 0, 0, 0);
		add_pixel(100, 0, 0, 0);
		add_pixel(170, 1, 1, 0);
		add_pixel(180, 0, 0, 0);
		add_pixel(179, 0, 0, 0);
		add_pixel(300, 0, 0, 0);
		add_pixel(450, 0, 1, 0);
		add_pixel(5, 0, 0, 0);
		add_pixel(185, 0, 1, 0);

		total = 0;
		while (total < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 30);
			add_image(len, total == 0 || $urandom_range(0, 7) == 0);
			total += len;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_pixels.size() > 0)
			@(posedge clk);
		while (expected_hues.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("dominant_hue_window_search_top verification clean");
		else
			$display("dominant_hue_window_search_top verification failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("dominant_hue_window_search_top verification failed");
		$finish;
	end

endmodule
